[hdl/fdef_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the forward difference edge filter.
// Used by fdef_front, fdef_result and forward_difference_edge_filter.
package fdef_pkg;

  // Defaults for the top level parameters
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int PIXEL_BITS_DEF = 8;

  // Fixed field widths
  localparam int FW_BITS       = 13;
  localparam int ROW_BITS      = 16;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 1;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

  // Reset values of the configuration registers
  localparam logic [FW_BITS-1:0]  FRAME_WIDTH_RESET  = 13'd4096;
  localparam logic [ROW_BITS-1:0] FRAME_HEIGHT_RESET = 16'd4096;

  // Number of result slots one pixel can fill
  localparam int SLOTS = 4;

  // Position flags of a captured pixel
  typedef struct packed {
    logic row_end;   // last column of its row
    logic last_row;  // last row of the frame
    logic has_above; // row above exists
    logic has_left;  // column to the left exists
  } fdef_ctl_t;

endpackage

[hdl/fdef_ram.sv]
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read.
// Read returns the old data on a same-address write. No dependencies.
module fdef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; read data holds between reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/fdef_front.sv]
`timescale 1ns / 1ps
// Input side: configuration registers, column and row counters, line store
// and the input register. Depends on fdef_pkg and fdef_ram.
module fdef_front #(
  parameter int MAX_WIDTH  = fdef_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = fdef_pkg::PIXEL_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fdef_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [fdef_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                               pixel_valid,
  output logic                               pixel_ready,
  input  logic [PIXEL_BITS-1:0]              pixel_value,
  input  logic                               a_take,
  output logic                               a_valid,
  output logic [PIXEL_BITS-1:0]              a_pix,
  output logic [PIXEL_BITS-1:0]              a_above,
  output logic [$clog2(MAX_WIDTH)-1:0]       a_col,
  output logic [fdef_pkg::ROW_BITS-1:0]      a_row,
  output fdef_pkg::fdef_ctl_t                a_ctl
);

  localparam int COL_BITS = $clog2(MAX_WIDTH);

  logic [fdef_pkg::FW_BITS-1:0]  frame_width;
  logic [fdef_pkg::ROW_BITS-1:0] frame_height;
  logic [COL_BITS-1:0]           column_count;
  logic [fdef_pkg::ROW_BITS-1:0] row_count;
  logic [COL_BITS-1:0]           w_last;
  logic [fdef_pkg::ROW_BITS-1:0] h_last;
  logic                          row_end;
  logic                          last_row;
  logic                          accept;

  assign cfg_ready   = 1'b1;
  assign pixel_ready = !a_valid || a_take;
  assign accept      = pixel_valid && pixel_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= fdef_pkg::FRAME_WIDTH_RESET;
      frame_height <= fdef_pkg::FRAME_HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        fdef_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[fdef_pkg::FW_BITS-1:0];
        fdef_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Last column and last row; zero counts as one, width saturates at the store size
  always_comb begin
    if (frame_width == '0) begin
      w_last = '0;
    end else if (int'(frame_width) > MAX_WIDTH) begin
      w_last = COL_BITS'(MAX_WIDTH - 1);
    end else begin
      w_last = COL_BITS'(frame_width - 1'b1);
    end
    if (frame_height == '0) begin
      h_last = '0;
    end else begin
      h_last = frame_height - 1'b1;
    end
  end

  assign row_end  = column_count >= w_last;
  assign last_row = row_count >= h_last;

  // Advance raster position on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (row_end) begin
        column_count <= '0;
        if (last_row) begin
          row_count <= '0;
        end else begin
          row_count <= row_count + 1'b1;
        end
      end else begin
        column_count <= column_count + 1'b1;
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (a_take) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_pix              <= pixel_value;
      a_col              <= column_count;
      a_row              <= row_count;
      a_ctl.row_end      <= row_end;
      a_ctl.last_row     <= last_row;
      a_ctl.has_above    <= row_count != '0;
      a_ctl.has_left     <= column_count != '0;
    end
  end

  // Line store: read the pixel above, then replace it with the current one
  fdef_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (accept),
    .waddr (column_count),
    .wdata (pixel_value),
    .re    (accept),
    .raddr (column_count),
    .rdata (a_above)
  );

endmodule

[hdl/fdef_result.sv]
`timescale 1ns / 1ps
// Result side: difference arithmetic, four-slot result buffer and output
// register. Depends on fdef_pkg.
module fdef_result #(
  parameter int MAX_WIDTH  = fdef_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = fdef_pkg::PIXEL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          a_valid,
  input  logic [PIXEL_BITS-1:0]         a_pix,
  input  logic [PIXEL_BITS-1:0]         a_above,
  input  logic [$clog2(MAX_WIDTH)-1:0]  a_col,
  input  logic [fdef_pkg::ROW_BITS-1:0] a_row,
  input  fdef_pkg::fdef_ctl_t           a_ctl,
  output logic                          a_take,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [PIXEL_BITS:0]           edge_value,
  output logic [fdef_pkg::ROW_BITS-1:0] out_row,
  output logic [$clog2(MAX_WIDTH)-1:0]  out_col,
  output logic                          last_of_run,
  output logic                          frame_done
);

  localparam int COL_BITS  = $clog2(MAX_WIDTH);
  localparam int EDGE_BITS = PIXEL_BITS + 1;
  localparam int SLOTS     = fdef_pkg::SLOTS;

  logic [PIXEL_BITS-1:0]         left_pixel;
  logic [PIXEL_BITS-1:0]         above_left_pixel;
  logic [SLOTS-1:0]              pend;
  logic [SLOTS-1:0]              pend_next;
  logic [EDGE_BITS-1:0]          slot_edge [SLOTS];
  logic [fdef_pkg::ROW_BITS-1:0] slot_row  [SLOTS];
  logic [COL_BITS-1:0]           slot_col  [SLOTS];
  logic [SLOTS-1:0]              slot_last;
  logic [SLOTS-1:0]              slot_done;

  logic [PIXEL_BITS-1:0]         d_left;
  logic [PIXEL_BITS-1:0]         d_up;
  logic [PIXEL_BITS-1:0]         d_cur_above;
  logic [PIXEL_BITS-1:0]         d_cur_left;
  logic [EDGE_BITS-1:0]          new_edge [SLOTS];
  logic [fdef_pkg::ROW_BITS-1:0] new_row  [SLOTS];
  logic [COL_BITS-1:0]           new_col  [SLOTS];
  logic [SLOTS-1:0]              new_en;
  logic [SLOTS-1:0]              new_last;
  logic                          seen_later;

  logic [1:0]                    sel;
  logic [SLOTS-1:0]              sel_hot;
  logic                          out_load;
  logic [SLOTS-1:0]              pend_after;

  // Absolute differences against the neighbors
  always_comb begin
    d_left      = (left_pixel >= above_left_pixel) ? left_pixel - above_left_pixel
                                                   : above_left_pixel - left_pixel;
    d_up        = (a_above >= above_left_pixel) ? a_above - above_left_pixel
                                                : above_left_pixel - a_above;
    d_cur_above = (a_pix >= a_above) ? a_pix - a_above : a_above - a_pix;
    d_cur_left  = (a_pix >= left_pixel) ? a_pix - left_pixel : left_pixel - a_pix;
  end

  // Candidate results in emission order
  always_comb begin
    new_edge[0] = {1'b0, d_left} + {1'b0, d_up};
    new_row[0]  = a_row - 1'b1;
    new_col[0]  = a_col - 1'b1;
    new_en[0]   = a_ctl.has_above && a_ctl.has_left;

    new_edge[1] = {1'b0, d_cur_above};
    new_row[1]  = a_row - 1'b1;
    new_col[1]  = a_col;
    new_en[1]   = a_ctl.has_above && a_ctl.row_end;

    new_edge[2] = {1'b0, d_cur_left};
    new_row[2]  = a_row;
    new_col[2]  = a_col - 1'b1;
    new_en[2]   = a_ctl.last_row && a_ctl.has_left;

    new_edge[3] = '0;
    new_row[3]  = a_row;
    new_col[3]  = a_col;
    new_en[3]   = a_ctl.last_row && a_ctl.row_end;
  end

  // Mark the last enabled slot of this pixel
  always_comb begin
    seen_later = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      new_last[i] = new_en[i] && !seen_later;
      seen_later  = seen_later || new_en[i];
    end
  end

  // Pick the lowest pending slot
  always_comb begin
    sel = 2'd3;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (pend[i]) begin
        sel = 2'(i);
      end
    end
    sel_hot = '0;
    sel_hot[sel] = 1'b1;
  end

  assign out_load   = (pend != '0) && (!result_valid || result_ready);
  assign pend_after = out_load ? (pend & ~sel_hot) : pend;
  assign a_take     = a_valid && (pend_after == '0);
  assign pend_next  = a_take ? new_en : pend_after;

  // Result buffer and neighbor history
  always_ff @(posedge clk) begin
    if (rst) begin
      pend             <= '0;
      left_pixel       <= '0;
      above_left_pixel <= '0;
    end else begin
      pend <= pend_next;
      if (a_take) begin
        left_pixel       <= a_pix;
        above_left_pixel <= a_above;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_take) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_edge[i] <= new_edge[i];
        slot_row[i]  <= new_row[i];
        slot_col[i]  <= new_col[i];
        slot_last[i] <= new_last[i];
        slot_done[i] <= new_last[i] && a_ctl.row_end && a_ctl.last_row;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      edge_value  <= slot_edge[sel];
      out_row     <= slot_row[sel];
      out_col     <= slot_col[sel];
      last_of_run <= slot_last[sel];
      frame_done  <= slot_done[sel];
    end
  end

endmodule

[hdl/forward_difference_edge_filter.sv]
`timescale 1ns / 1ps
// Streaming forward difference edge filter, top level.
// Depends on fdef_pkg, fdef_front, fdef_result and fdef_ram.
//
// Pixels enter in raster order, one per cycle when the result side keeps
// up; each pixel gives |lower - own| + |right - own| once its lower
// neighbor has arrived, with a difference to an out-of-frame neighbor
// counting as zero, so results lag by about one row and carry their own
// row and column. An input pixel yields zero to four results, one leaves
// the output register per cycle while result_ready allows it: the result
// side sets the rate, with up to one result per pixel inside the frame
// plus one more at each row end, and up to two per pixel in the last row
// (plus two more at the end of that row). The first result of a pixel
// passes the input register with line store read, the result buffer and
// the output register. The line store is a single RAM of MAX_WIDTH
// pixels; a write to frame_width or frame_height takes effect from the
// next accepted pixel, also within a frame, where a column or row at or
// beyond the new last index ends the row or the frame. The first row of a
// frame has no results unless the frame is one row high.
module forward_difference_edge_filter #(
  parameter int MAX_WIDTH  = fdef_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = fdef_pkg::PIXEL_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fdef_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [fdef_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                               pixel_valid,
  output logic                               pixel_ready,
  input  logic [PIXEL_BITS-1:0]              pixel_value,
  output logic                               result_valid,
  input  logic                               result_ready,
  output logic [PIXEL_BITS:0]                edge_value,
  output logic [fdef_pkg::ROW_BITS-1:0]      out_row,
  output logic [$clog2(MAX_WIDTH)-1:0]       out_col,
  output logic                               last_of_run,
  output logic                               frame_done
);

  localparam int COL_BITS = $clog2(MAX_WIDTH);

  logic                          a_take;
  logic                          a_valid;
  logic [PIXEL_BITS-1:0]         a_pix;
  logic [PIXEL_BITS-1:0]         a_above;
  logic [COL_BITS-1:0]           a_col;
  logic [fdef_pkg::ROW_BITS-1:0] a_row;
  fdef_pkg::fdef_ctl_t           a_ctl;

  // Counters, configuration, line store and input register
  fdef_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel_value (pixel_value),
    .a_take      (a_take),
    .a_valid     (a_valid),
    .a_pix       (a_pix),
    .a_above     (a_above),
    .a_col       (a_col),
    .a_row       (a_row),
    .a_ctl       (a_ctl)
  );

  // Difference arithmetic, result buffer and output register
  fdef_result #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_result (
    .clk          (clk),
    .rst          (rst),
    .a_valid      (a_valid),
    .a_pix        (a_pix),
    .a_above      (a_above),
    .a_col        (a_col),
    .a_row        (a_row),
    .a_ctl        (a_ctl),
    .a_take       (a_take),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .edge_value   (edge_value),
    .out_row      (out_row),
    .out_col      (out_col),
    .last_of_run  (last_of_run),
    .frame_done   (frame_done)
  );

endmodule
